// ===== hdl/rps_pkg.sv =====
// Shared types and constants for the radial particle splitting block.
package rps_pkg;

  localparam int CNT_W  = 11;          // stack counts and split factor
  localparam int FQ_W   = 2 * CNT_W;   // saturating quotient r2 / rmin^2
  localparam int ROOT_W = CNT_W;       // integer root of that quotient
  localparam int CFG_W  = 32;

  typedef enum logic [2:0] {
    REG_MIN_WEIGHT = 3'd0,
    REG_MAX_WEIGHT = 3'd1,
    REG_CENTER_X   = 3'd2,
    REG_CENTER_Y   = 3'd3,
    REG_CENTER_Z   = 3'd4,
    REG_RADIUS_MIN = 3'd5,
    REG_RADIUS_MAX = 3'd6,
    REG_LINEAR     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        particle_weight;
    logic [10:0]        stack_used;
    logic [10:0]        stack_capacity;
  } rps_in_t;

  typedef struct packed {
    logic        did_split;
    logic [10:0] split_factor;
    logic [9:0]  clone_count;
    logic [31:0] new_weight;
    logic [10:0] stack_used_after;
  } rps_out_t;

  typedef struct packed {
    logic [31:0]        min_weight;
    logic [31:0]        max_weight;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius_min;
    logic [30:0]        radius_max;
    logic               linear_mode;
  } rps_cfg_t;

  // Per-particle control carried alongside the factor computation.
  typedef struct packed {
    logic             ok;
    logic             linear;
    logic [31:0]      weight;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] freesp;
  } rps_front_t;

endpackage

// ===== hdl/rps_geom.sv =====
// Front pipeline: distance squared, shell and weight window tests, free stack space.
module rps_geom #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  rps_pkg::rps_in_t  in_data,
  input  rps_pkg::rps_cfg_t cfg,
  output logic              out_vld,
  output logic [63:0]       r2,
  output logic [61:0]       rmin2,
  output rps_pkg::rps_front_t front
);
  import rps_pkg::*;

  logic [61:0] rmin_sq, rmax_sq;

  // stage 1
  logic              v1;
  logic signed [32:0] dx1, dy1, dz1;
  logic              wok1, lin1;
  logic [31:0]       w1;
  logic [CNT_W-1:0]  used1, free1;
  // stage 2
  logic              v2, far2, wok2, lin2;
  logic [30:0]       ax2, ay2, az2;
  logic [31:0]       w2;
  logic [CNT_W-1:0]  used2, free2;
  // stage 3
  logic              v3, far3, wok3, lin3;
  logic [61:0]       sx3, sy3, sz3;
  logic [31:0]       w3;
  logic [CNT_W-1:0]  used3, free3;
  // stage 4
  logic              v4, far4, wok4, lin4;
  logic [63:0]       r2_4;
  logic [31:0]       w4;
  logic [CNT_W-1:0]  used4, free4;

  logic [CNT_W-1:0]  capc;
  logic [32:0]       mx, my, mz;

  // radii are to change only while idle, which the block does not enforce; squares follow in the next cycle
  always_ff @(posedge clk) begin
    rmin_sq <= 62'(cfg.radius_min) * 62'(cfg.radius_min);
    rmax_sq <= 62'(cfg.radius_max) * 62'(cfg.radius_max);
  end

  always_comb begin
    capc = (int'({21'b0, in_data.stack_capacity}) > STACK_DEPTH) ?
           CNT_W'(STACK_DEPTH) : in_data.stack_capacity;
    mx = dx1[32] ? 33'(-dx1) : 33'(dx1);
    my = dy1[32] ? 33'(-dy1) : 33'(dy1);
    mz = dz1[32] ? 33'(-dz1) : 33'(dz1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld; v2 <= v1; v3 <= v2; v4 <= v3; out_vld <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1   <= {in_data.pos_x[31], in_data.pos_x} - {cfg.center_x[31], cfg.center_x};
      dy1   <= {in_data.pos_y[31], in_data.pos_y} - {cfg.center_y[31], cfg.center_y};
      dz1   <= {in_data.pos_z[31], in_data.pos_z} - {cfg.center_z[31], cfg.center_z};
      wok1  <= (in_data.particle_weight >= cfg.min_weight) &&
               (in_data.particle_weight < cfg.max_weight);
      lin1  <= cfg.linear_mode;
      w1    <= in_data.particle_weight;
      used1 <= in_data.stack_used;
      free1 <= (capc > in_data.stack_used) ? capc - in_data.stack_used : '0;

      far2 <= mx[32] | mx[31] | my[32] | my[31] | mz[32] | mz[31];
      ax2  <= mx[30:0]; ay2 <= my[30:0]; az2 <= mz[30:0];
      wok2 <= wok1; lin2 <= lin1; w2 <= w1; used2 <= used1; free2 <= free1;

      sx3  <= 62'(ax2) * 62'(ax2);
      sy3  <= 62'(ay2) * 62'(ay2);
      sz3  <= 62'(az2) * 62'(az2);
      far3 <= far2; wok3 <= wok2; lin3 <= lin2; w3 <= w2; used3 <= used2; free3 <= free2;

      r2_4 <= 64'(sx3) + 64'(sy3) + 64'(sz3);
      far4 <= far3; wok4 <= wok3; lin4 <= lin3; w4 <= w3; used4 <= used3; free4 <= free3;

      r2           <= r2_4;
      rmin2        <= rmin_sq;
      front.ok     <= wok4 && !far4 && (r2_4 >= 64'(rmin_sq)) && (r2_4 < 64'(rmax_sq));
      front.linear <= lin4;
      front.weight <= w4;
      front.used   <= used4;
      front.freesp <= free4;
    end
  end

endmodule

// ===== hdl/rps_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating on overflow.
module rps_div #(
  parameter int NW = 64,
  parameter int DW = 62,
  parameter int QW = 22,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_vld,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);
  localparam int XW = (NW > DW + QW) ? NW + 1 : DW + QW + 1;

  logic          vld   [QW+1];
  logic [NW-1:0] rem   [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] q     [QW+1];
  logic          sat   [QW+1];
  logic [SW-1:0] side_r[QW+1];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]    <= num;
      den_r[0]  <= den;
      q[0]      <= '0;
      sat[0]    <= XW'(num) >= (XW'(den) << QW);
      side_r[0] <= side;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic [XW-1:0] trial;
    logic          ge;
    assign trial = XW'(den_r[s-1]) << (QW - s);
    assign ge    = XW'(rem[s-1]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) vld[s] <= 1'b0;
      else if (en) vld[s] <= vld[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]    <= ge ? NW'(XW'(rem[s-1]) - trial) : rem[s-1];
        q[s]      <= q[s-1] | (ge ? (QW'(1) << (QW - s)) : '0);
        den_r[s]  <= den_r[s-1];
        sat[s]    <= sat[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign out_vld  = vld[QW];
  assign quo      = q[QW] | {QW{sat[QW]}};
  assign side_out = side_r[QW];

endmodule

// ===== hdl/rps_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module rps_isqrt #(
  parameter int VW = 22,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [VW-1:0]   val,
  input  logic [SW-1:0]   side,
  output logic            out_vld,
  output logic [VW/2-1:0] root,
  output logic [SW-1:0]   side_out
);
  localparam int RW = VW / 2;

  logic          vld   [RW+1];
  logic [VW-1:0] v     [RW+1];
  logic [RW-1:0] res   [RW+1];
  logic [SW-1:0] side_r[RW+1];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v[0]      <= val;
      res[0]    <= '0;
      side_r[0] <= side;
    end
  end

  for (genvar s = 1; s <= RW; s++) begin : g_stage
    logic [RW-1:0]   trial;
    logic [2*RW-1:0] sq;
    assign trial = res[s-1] | (RW'(1) << (RW - s));
    assign sq    = (2*RW)'(trial) * (2*RW)'(trial);

    always_ff @(posedge clk) begin
      if (rst) vld[s] <= 1'b0;
      else if (en) vld[s] <= vld[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res[s]    <= ((2*RW)'(v[s-1]) >= sq) ? trial : res[s-1];
        v[s]      <= v[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign out_vld  = vld[RW];
  assign root     = res[RW];
  assign side_out = side_r[RW];

endmodule

// ===== hdl/radial_particle_splitting.sv =====
// Top level of the radial particle splitting block.
//
// Input channel in_valid/in_stall/in_data carries one particle request:
// position, weight, stack slots used and stack capacity. Output channel
// out_valid/out_stall/out_data returns one result per request, in order:
// split flag, split factor, clone count, reduced weight, new stack fill.
// The user must write registers via cfg_we/cfg_index/cfg_data only while idle (unenforced).
//
// The pipeline has 5 front stages (distance squared, window tests), 23 stages
// of the factor divider (an input stage, then one quotient bit each), 12 stages of
// the integer root, one factor select stage, 33 stages of the weight
// divider and the output register. A new request is taken every cycle while in_stall is low.
// When out_valid is high and out_stall is asserted, the whole pipeline
// holds and in_stall rises in the same cycle; nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads the register defaults
// (full weight window, centre at origin, radii 1.0 and 10.0, quadratic).
module radial_particle_splitting #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rps_pkg::rps_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rps_pkg::rps_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import rps_pkg::*;

  localparam int FW  = $bits(rps_front_t);
  localparam int SW2 = 1 + CNT_W + CNT_W;

  rps_cfg_t   cfg;
  logic       en;

  logic       g_vld;
  logic [63:0] g_r2;
  logic [61:0] g_rmin2;
  rps_front_t g_front;

  logic       d_vld;
  logic [FQ_W-1:0] d_q;
  logic [FW-1:0]   d_side;

  logic       s_vld;
  logic [ROOT_W-1:0] s_root;
  logic [FW+FQ_W-1:0] s_side;
  rps_front_t s_front;
  logic [FQ_W-1:0] s_q;

  logic [FQ_W-1:0] factor;
  logic [FQ_W-1:0] n_wide;

  logic       m_vld, m_split;
  logic [CNT_W-1:0] m_n, m_used_after;
  logic [31:0] m_weight;

  logic       w_vld;
  logic [31:0] w_quo;
  logic [SW2-1:0] w_side;
  logic       w_split;
  logic [CNT_W-1:0] w_n, w_used_after;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_weight  <= '0;
      cfg.max_weight  <= '1;
      cfg.center_x    <= '0;
      cfg.center_y    <= '0;
      cfg.center_z    <= '0;
      cfg.radius_min  <= 31'd65536;
      cfg.radius_max  <= 31'd655360;
      cfg.linear_mode <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MIN_WEIGHT: cfg.min_weight  <= cfg_data;
        REG_MAX_WEIGHT: cfg.max_weight  <= cfg_data;
        REG_CENTER_X:   cfg.center_x    <= cfg_data;
        REG_CENTER_Y:   cfg.center_y    <= cfg_data;
        REG_CENTER_Z:   cfg.center_z    <= cfg_data;
        REG_RADIUS_MIN: cfg.radius_min  <= cfg_data[30:0];
        REG_RADIUS_MAX: cfg.radius_max  <= cfg_data[30:0];
        REG_LINEAR:     cfg.linear_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rps_geom #(.STACK_DEPTH(STACK_DEPTH)) u_geom (
    .clk, .rst, .en,
    .in_vld  (in_valid),
    .in_data (in_data),
    .cfg     (cfg),
    .out_vld (g_vld),
    .r2      (g_r2),
    .rmin2   (g_rmin2),
    .front   (g_front)
  );

  // floor(r2 / rmin^2), saturated; a zero radius saturates too
  rps_div #(.NW(64), .DW(62), .QW(FQ_W), .SW(FW)) u_fdiv (
    .clk, .rst, .en,
    .in_vld   (g_vld),
    .num      (g_r2),
    .den      (g_rmin2),
    .side     (g_front),
    .out_vld  (d_vld),
    .quo      (d_q),
    .side_out (d_side)
  );

  // linear factor is the root of the quadratic one
  rps_isqrt #(.VW(FQ_W), .SW(FW + FQ_W)) u_root (
    .clk, .rst, .en,
    .in_vld   (d_vld),
    .val      (d_q),
    .side     ({d_side, d_q}),
    .out_vld  (s_vld),
    .root     (s_root),
    .side_out (s_side)
  );

  always_comb begin
    s_front = rps_front_t'(s_side[FW+FQ_W-1:FQ_W]);
    s_q     = s_side[FQ_W-1:0];
    factor  = s_front.linear ? FQ_W'(s_root) : s_q;
    n_wide  = (factor < FQ_W'(s_front.freesp)) ? factor : FQ_W'(s_front.freesp);
  end

  always_ff @(posedge clk) begin
    if (rst) m_vld <= 1'b0;
    else if (en) m_vld <= s_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_split      <= s_front.ok && (n_wide > FQ_W'(1));
      m_n          <= n_wide[CNT_W-1:0];
      m_weight     <= s_front.weight;
      m_used_after <= (s_front.ok && (n_wide > FQ_W'(1))) ?
                      s_front.used + n_wide[CNT_W-1:0] - CNT_W'(1) : s_front.used;
    end
  end

  // divide by one when there is no split, which passes the weight through
  rps_div #(.NW(32), .DW(CNT_W), .QW(32), .SW(SW2)) u_wdiv (
    .clk, .rst, .en,
    .in_vld   (m_vld),
    .num      (m_weight),
    .den      (m_split ? m_n : CNT_W'(1)),
    .side     ({m_split, m_n, m_used_after}),
    .out_vld  (w_vld),
    .quo      (w_quo),
    .side_out (w_side)
  );

  assign {w_split, w_n, w_used_after} = w_side;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= w_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.did_split        <= w_split;
      out_data.split_factor     <= w_split ? w_n : CNT_W'(1);
      out_data.clone_count      <= w_split ? 10'(w_n - CNT_W'(1)) : '0;
      out_data.new_weight       <= w_quo;
      out_data.stack_used_after <= w_used_after;
    end
  end

endmodule

// ===== sim/radial_particle_splitting_checker.sv =====
// Checker for the radial particle splitting block: predicts and compares results.
module radial_particle_splitting_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  rps_pkg::rps_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  rps_pkg::rps_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output int                fail_count,
  output int                pending
);
  import rps_pkg::*;

  localparam int DEPTH = 1024;

  rps_cfg_t cfg;
  rps_out_t split_q[$];

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic rps_out_t predict_split(rps_in_t p);
    rps_out_t r;
    longint signed ddx, ddy, ddz;
    logic [63:0] ax, ay, az, r2, rmin2, rmax2, factor, cap, freesp, n;
    r.did_split = 1'b0;
    r.split_factor = 11'd1;
    r.clone_count = '0;
    r.new_weight = p.particle_weight;
    r.stack_used_after = p.stack_used;
    if (p.particle_weight < cfg.min_weight || p.particle_weight >= cfg.max_weight)
      return r;
    ddx = longint'(p.pos_x) - longint'(cfg.center_x);
    ddy = longint'(p.pos_y) - longint'(cfg.center_y);
    ddz = longint'(p.pos_z) - longint'(cfg.center_z);
    ax = ddx < 0 ? -ddx : ddx;
    ay = ddy < 0 ? -ddy : ddy;
    az = ddz < 0 ? -ddz : ddz;
    if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000 || az >= 64'h8000_0000) return r;
    r2 = ax * ax + ay * ay + az * az;
    rmin2 = 64'(cfg.radius_min) * 64'(cfg.radius_min);
    rmax2 = 64'(cfg.radius_max) * 64'(cfg.radius_max);
    if (r2 < rmin2 || r2 >= rmax2) return r;
    if (cfg.radius_min == 0) factor = '1;
    else if (cfg.linear_mode) factor = int_root(r2) / 64'(cfg.radius_min);
    else factor = r2 / rmin2;
    cap = p.stack_capacity > DEPTH ? DEPTH : 64'(p.stack_capacity);
    freesp = cap > 64'(p.stack_used) ? cap - 64'(p.stack_used) : 0;
    n = factor < freesp ? factor : freesp;
    if (n <= 1) return r;
    r.did_split = 1'b1;
    r.split_factor = n[10:0];
    r.clone_count = 10'(n - 1);
    r.new_weight = 32'(64'(p.particle_weight) / n);
    r.stack_used_after = 11'(64'(p.stack_used) + n - 1);
    return r;
  endfunction

  assign pending = split_q.size();

  always @(posedge clk) begin
    rps_out_t want;
    if (rst) begin
      cfg <= '{min_weight: 32'd0, max_weight: 32'hFFFF_FFFF, center_x: 0, center_y: 0,
               center_z: 0, radius_min: 31'd65536, radius_max: 31'd655360,
               linear_mode: 1'b0};
      split_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MIN_WEIGHT: cfg.min_weight <= cfg_data;
          REG_MAX_WEIGHT: cfg.max_weight <= cfg_data;
          REG_CENTER_X:   cfg.center_x <= cfg_data;
          REG_CENTER_Y:   cfg.center_y <= cfg_data;
          REG_CENTER_Z:   cfg.center_z <= cfg_data;
          REG_RADIUS_MIN: cfg.radius_min <= cfg_data[30:0];
          REG_RADIUS_MAX: cfg.radius_max <= cfg_data[30:0];
          REG_LINEAR:     cfg.linear_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) split_q.push_back(predict_split(in_data));
      if (out_valid && !out_stall) begin
        if (split_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = split_q.pop_front();
          if (want.did_split !== out_data.did_split
              || want.split_factor !== out_data.split_factor
              || want.clone_count !== out_data.clone_count
              || want.new_weight !== out_data.new_weight
              || want.stack_used_after !== out_data.stack_used_after) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/radial_particle_splitting_test.sv =====
// Testbench top: drives particle requests and registers, reports the verdict.
module radial_particle_splitting_test;
  import rps_pkg::*;

  localparam int LATENCY = 75;
  localparam int LIMIT   = 400000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  rps_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rps_out_t out_data;
  logic     cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int fail_count;
  int pending;
  int cycles = 0;
  bit stall_free;

  always #5 clk = ~clk;

  radial_particle_splitting u_dut (.*);

  radial_particle_splitting_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: unless stall_free is set, each result waits a random number of stalled cycles.
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (stall_free) begin
        out_stall <= 1'b0;
      end else if (out_stall) begin
        if (gap > 0) gap--;
        else out_stall <= 1'b0;
      end else if (out_valid) begin
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
          out_stall <= 1'b1;
          gap--;
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Leaves in_valid high after the handshake; the next gap or drain drops it.
  task automatic send_particle(rps_in_t p, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] near_coord(logic [31:0] c, int unsigned span);
    return c + $signed($urandom_range(0, 2 * span)) - $signed(span);
  endfunction

  // Mostly particles near the shell, with realistic stacks; some raw noise.
  function automatic rps_in_t shell_particle(logic [31:0] cx, logic [31:0] cy,
                                             logic [31:0] cz, int unsigned span);
    rps_in_t p;
    p.pos_x = near_coord(cx, span);
    p.pos_y = near_coord(cy, span);
    p.pos_z = near_coord(cz, span);
    p.particle_weight = $urandom();
    p.stack_used = 11'($urandom_range(0, 1024));
    p.stack_capacity = $urandom_range(0, 4) == 0 ? 11'($urandom()) :
                       11'($urandom_range(0, 1024));
    if ($urandom_range(0, 9) == 0) begin
      p.pos_x = $urandom();
      p.pos_y = $urandom();
      p.pos_z = $urandom();
      p.stack_used = 11'($urandom());
    end
    return p;
  endfunction

  initial begin
    rps_in_t p;
    logic [31:0] cx, cy, cz;
    int unsigned span;
    bit lin;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with reset settings (radii 1.0 and 10.0).
    stall_free = 1'b0;
    send_particle('{32'sd196608, 0, 0, 32'h0100_0000, 11'd0, 11'd1024}, 1'b0);
    send_particle('{32'sd655360, 0, 0, 32'hFFFF_FFFF, 11'd0, 11'd2047}, 1'b0);
    send_particle('{32'sd655359, 0, 0, 32'h0000_0000, 11'd5, 11'd10}, 1'b0);
    send_particle('{32'sd65535, 0, 0, 32'h1, 11'd0, 11'd100}, 1'b0);
    send_particle('{32'sd65536, 0, 0, 32'h1, 11'd0, 11'd100}, 1'b0);
    send_particle('{32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h5, 11'd0, 11'd100}, 1'b0);
    send_particle('{32'sd300000, 32'sd300000, 32'sd300000, 32'h9, 11'd1024, 11'd1024},
                  1'b0);
    send_particle('{32'sd300000, 0, 0, 32'h9, 11'd2047, 11'd3}, 1'b0);
    send_particle('{32'sd300000, 0, 0, 32'h9, 11'd2, 11'd3}, 1'b0);
    send_particle('{-32'sd400000, 0, 32'sd1, 32'h7FFF_FFFF, 11'd1023, 11'd1024}, 1'b0);
    drain();

    write_reg(REG_LINEAR, 32'd1);
    write_reg(REG_RADIUS_MIN, 32'd0);
    write_reg(REG_RADIUS_MAX, 32'h7FFF_FFFF);
    send_particle('{32'sd0, 0, 0, 32'h3, 11'd0, 11'd1024}, 1'b0);
    send_particle('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 11'd7,
                    11'd1024}, 1'b0);
    send_particle('{32'h8000_0001, 32'h7FFF_FFFF, 0, 32'h3, 11'd0, 11'd1024}, 1'b0);
    drain();
    write_reg(REG_RADIUS_MIN, 32'd700000);
    write_reg(REG_RADIUS_MAX, 32'd700000);
    send_particle('{32'sd700000, 0, 0, 32'h3, 11'd0, 11'd1024}, 1'b0);
    drain();
    write_reg(REG_MIN_WEIGHT, 32'h100);
    write_reg(REG_MAX_WEIGHT, 32'h200);
    send_particle('{32'sd700000, 0, 0, 32'hFF, 11'd0, 11'd1024}, 1'b0);
    send_particle('{32'sd700000, 0, 0, 32'h200, 11'd0, 11'd1024}, 1'b0);
    drain();

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 14; ph++) begin
      lin = ph[0];
      span = ph == 0 ? 32'h7FFF_FFFF : (1 << ($urandom_range(8, 26)));
      cx = ph == 1 ? 32'h8000_0000 : (ph == 2 ? 32'h7FFF_FFFF : $urandom());
      cy = $urandom();
      cz = ph == 3 ? 32'h8000_0000 : $urandom();
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      write_reg(REG_CENTER_Z, cz);
      write_reg(REG_RADIUS_MIN, ph == 4 ? 32'd1 : ph == 5 ? 32'h7FFF_FFFF
                                : $urandom_range(1, span / 8 + 1));
      write_reg(REG_RADIUS_MAX, ph == 6 ? 32'd2 : $urandom_range(span / 2, 2 * span));
      write_reg(REG_LINEAR, {31'd0, lin});
      write_reg(REG_MIN_WEIGHT, ph < 7 ? 32'd0 : $urandom_range(0, 32'h4000_0000));
      write_reg(REG_MAX_WEIGHT, ph < 7 ? 32'hFFFF_FFFF : $urandom_range(32'h8000_0000,
                                                                        32'hFFFF_FFFF));
      stall_free = (ph % 5 == 4);
      for (int i = 0; i < 100; i++) begin
        p = shell_particle(cx, cy, cz, span);
        send_particle(p, stall_free);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/rps_pkg.sv
hdl/rps_geom.sv
hdl/rps_div.sv
hdl/rps_isqrt.sv
hdl/radial_particle_splitting.sv
sim/radial_particle_splitting_checker.sv
sim/radial_particle_splitting_test.sv
